### rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared constants, types and register codes for the windowed score detector.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int SLOT_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
  localparam int SCORE_W    = 8;
  localparam int SUM_W      = SCORE_W + WIN_W;
  localparam int TOTAL_W    = 12;
  localparam int CNT_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int WSIZE_W    = 5;

  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COOLOFF = 2'd2;

  localparam logic [SCORE_W-1:0] CUTOFF_RST  = 8'd247;
  localparam logic [WSIZE_W-1:0] WINDOW_RST  = 5'd5;
  localparam logic [SCORE_W-1:0] COOLOFF_RST = 8'd74;

  typedef struct packed {
    logic                    clear;
    logic                    write;
    logic [SLOT_W-1:0]       slot;
    logic [SCORE_W-1:0]      score;
    logic signed [SUM_W-1:0] delta;
  } cell_ctrl_t;

  typedef struct packed {
    logic               detected;
    logic [TOTAL_W-1:0] window_total;
    logic               cooling;
  } result_t;

endpackage

### rtl/wsd_cell.sv
// ----------------------------------------------------------------------------
// wsd_cell
// One store slot: holds its score and the running sum of slots 0 up to itself.
// A write at or below this slot is handed up the row through act_out.
// ----------------------------------------------------------------------------
module wsd_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wsd_pkg::cell_ctrl_t             ctrl,
  input  logic [wsd_pkg::SLOT_W-1:0]      cell_idx,
  input  logic                            act_in,
  output logic                            act_out,
  output logic [wsd_pkg::SCORE_W-1:0]     score_q,
  output logic [wsd_pkg::SUM_W-1:0]       prefix_q
);
  import wsd_pkg::*;

  logic [SCORE_W-1:0] score_r, score_nxt;
  logic [SUM_W-1:0]   prefix_r, prefix_nxt;
  logic               hit;

  assign hit     = (ctrl.slot == cell_idx);
  assign act_out = act_in | hit;

  always_comb begin
    score_nxt  = score_r;
    prefix_nxt = prefix_r;
    if (ctrl.clear) begin
      score_nxt  = '0;
      prefix_nxt = '0;
    end else if (ctrl.write) begin
      if (hit) begin
        score_nxt = ctrl.score;
      end
      // the new score shifts every prefix sum from its slot upward
      if (act_out) begin
        prefix_nxt = prefix_r + SUM_W'(ctrl.delta);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r  <= '0;
      prefix_r <= '0;
    end else begin
      score_r  <= score_nxt;
      prefix_r <= prefix_nxt;
    end
  end

  assign score_q  = score_r;
  assign prefix_q = prefix_r;

endmodule

### rtl/wsd_out_buf.sv
// ----------------------------------------------------------------------------
// wsd_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module wsd_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  wsd_pkg::result_t load_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output wsd_pkg::result_t out_data
);
  import wsd_pkg::*;

  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    take;

  assign take = main_valid_r & ~out_stall;
  assign full = skid_valid_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (take) begin
      main_valid_nxt = 1'b0;
    end
    if (skid_valid_r && take) begin
      // advance the waiting result
      main_valid_nxt = 1'b1;
      main_nxt       = skid_r;
      skid_valid_nxt = 1'b0;
    end
    if (load) begin
      if (!main_valid_r || take) begin
        main_valid_nxt = 1'b1;
        main_nxt       = load_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = load_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

### rtl/windowed_score_detector.sv
// ----------------------------------------------------------------------------
// windowed_score_detector
// Sliding-window score sum with cool-off and threshold detection.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_stall   | score, clear_request
//  out_    | output    | out_valid / out_stall | detected, window_total, cooling
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One item per cycle while in_stall is low; its result is registered in the output buffer.
//  Each store cell keeps a prefix sum, so the window sum is one mux and one
//  add; a write updates all prefixes at and above its slot in that cycle.
//  Reset clears the store and loads the register defaults.
//  A result waits in a two-entry buffer; in_stall rises only when both are full.
// ----------------------------------------------------------------------------
module windowed_score_detector (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [wsd_pkg::SCORE_W-1:0]       in_score,
  input  logic                              in_clear_request,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_detected,
  output logic [wsd_pkg::TOTAL_W-1:0]       out_window_total,
  output logic                              out_cooling,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wsd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wsd_pkg::*;

  logic [SCORE_W-1:0]      cutoff_r, cutoff_nxt;
  logic [WSIZE_W-1:0]      window_r, window_nxt;
  logic [SCORE_W-1:0]      cooloff_r, cooloff_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic signed [CNT_W-1:0] cnt_r, cnt_nxt;

  logic                    accept, full;
  logic [WIN_W-1:0]        win;
  logic [WIN_W-1:0]        slot_inc;
  logic [SLOT_W-1:0]       next_slot, last_slot;
  logic [SUM_W-1:0]        total;
  logic [SUM_W-1:0]        thresh;
  logic signed [SUM_W-1:0] delta;
  logic signed [CNT_W-1:0] cnt_upd, cnt_reload;
  logic                    detect, restart;
  cell_ctrl_t              ctrl;
  result_t                 res;
  result_t                 out_data;

  logic [MAX_WINDOW-1:0]   act;
  logic [SCORE_W-1:0]      cell_score [MAX_WINDOW];
  logic [SUM_W-1:0]        cell_prefix [MAX_WINDOW];

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid & ~full;

  // ---- configuration ----
  always_comb begin
    cutoff_nxt  = cutoff_r;
    window_nxt  = window_r;
    cooloff_nxt = cooloff_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_CUTOFF:  cutoff_nxt  = cfg_data;
        REG_WINDOW:  window_nxt  = cfg_data[WSIZE_W-1:0];
        REG_COOLOFF: cooloff_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // ---- effective window and write slot ----
  always_comb begin
    if (window_r == '0) begin
      win = WIN_W'(1);
    end else if (32'(window_r) > 32'(MAX_WINDOW)) begin
      win = WIN_W'(MAX_WINDOW);
    end else begin
      win = WIN_W'(window_r);
    end
  end

  assign slot_inc  = WIN_W'(slot_r) + WIN_W'(1);
  assign next_slot = (slot_inc >= win) ? '0 : SLOT_W'(slot_inc);
  assign last_slot = SLOT_W'(win - WIN_W'(1));

  // ---- sum, threshold and cool-off ----
  assign delta  = $signed(SUM_W'(in_score)) - $signed(SUM_W'(cell_score[next_slot]));
  // the new slot never lies above the window's last slot
  assign total  = cell_prefix[last_slot] + SUM_W'(delta);
  assign thresh = SUM_W'(cutoff_r) * SUM_W'(win);

  assign cnt_reload = -$signed({1'b0, cooloff_r});
  assign cnt_upd    = ((in_score < cutoff_r) && cnt_r[CNT_W-1]) ? cnt_r + CNT_W'(1) : cnt_r;
  assign detect     = ~in_clear_request & ~cnt_upd[CNT_W-1] & (total > thresh);
  assign restart    = in_clear_request | detect;

  always_comb begin
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    if (accept) begin
      slot_nxt = restart ? '0 : next_slot;
      cnt_nxt  = restart ? cnt_reload : cnt_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r  <= CUTOFF_RST;
      window_r  <= WINDOW_RST;
      cooloff_r <= COOLOFF_RST;
      slot_r    <= '0;
      cnt_r     <= -$signed({1'b0, COOLOFF_RST});
    end else begin
      cutoff_r  <= cutoff_nxt;
      window_r  <= window_nxt;
      cooloff_r <= cooloff_nxt;
      slot_r    <= slot_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // ---- store cells ----
  always_comb begin
    ctrl.clear = accept & restart;
    ctrl.write = accept & ~restart;
    ctrl.slot  = next_slot;
    ctrl.score = in_score;
    ctrl.delta = delta;
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
      logic act_prev;
      if (gi == 0) begin : g_first
        assign act_prev = 1'b0;
      end else begin : g_rest
        assign act_prev = act[gi-1];
      end
      wsd_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .cell_idx (SLOT_W'(gi)),
        .act_in   (act_prev),
        .act_out  (act[gi]),
        .score_q  (cell_score[gi]),
        .prefix_q (cell_prefix[gi])
      );
    end
  endgenerate

  // ---- result ----
  always_comb begin
    res.detected     = detect;
    res.window_total = in_clear_request ? '0 : TOTAL_W'(total);
    res.cooling      = cnt_nxt[CNT_W-1];
  end

  wsd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .load_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_detected     = out_data.detected;
  assign out_window_total = out_data.window_total;
  assign out_cooling      = out_data.cooling;

endmodule

### dv/windowed_score_detector_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_score_detector_test
// Drives scores and clear requests into the detector and predicts each result
// (window sum, cool-off, detection) from its own copy of the store. It covers
// directed corner cases, back-pressure and randomized arm-and-fire traffic
// across several register settings, with random sender and receiver stalls.
// ----------------------------------------------------------------------------
module windowed_score_detector_test;
  import wsd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int QUIET_LIMIT      = 3000;
  localparam int SHOWN_MISMATCHES = 10;

  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  in_valid         = 1'b0;
  logic                  in_stall;
  logic [SCORE_W-1:0]    in_score         = '0;
  logic                  in_clear_request = 1'b0;
  logic                  out_valid;
  logic                  out_stall        = 1'b0;
  logic                  out_detected;
  logic [TOTAL_W-1:0]    out_window_total;
  logic                  out_cooling;
  logic                  cfg_valid        = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index        = '0;
  logic [CFG_DATA_W-1:0] cfg_data         = '0;

  // predicted detector state
  logic [SCORE_W-1:0] cutoff_q;
  logic [WSIZE_W-1:0] wsize_q;
  logic [SCORE_W-1:0] cooloff_q;
  logic [SCORE_W-1:0] score_mem [MAX_WINDOW];
  int                 slot_q;
  int                 cool_count;

  result_t expected_results [$];
  int      mismatch_count = 0;
  int      accepted_items = 0;
  int      idle_pct       = 0;
  int      stall_pct      = 0;
  int      hold_cycles    = 0;
  int      quiet_cycles   = 0;

  windowed_score_detector dut (.*);

  always #6 clk = ~clk;

  function automatic int active_window();
    if (wsize_q == 0) return 1;
    if (wsize_q > MAX_WINDOW) return MAX_WINDOW;
    return int'(wsize_q);
  endfunction

  function automatic void restart_detector();
    foreach (score_mem[i]) score_mem[i] = '0;
    slot_q = 0;
    cool_count = -int'(cooloff_q);
  endfunction

  function automatic result_t score_step(logic [SCORE_W-1:0] score, logic clr);
    result_t res;
    int      win;
    int      total;
    win = active_window();
    total = 0;
    res = '0;
    if (clr) begin
      restart_detector();
    end else begin
      // advance the slot first, then write
      slot_q = (slot_q + 1 >= win) ? 0 : slot_q + 1;
      score_mem[slot_q] = score;
      if (score < cutoff_q && cool_count < 0) cool_count++;
      for (int i = 0; i < win; i++) total += score_mem[i];
      if (cool_count >= 0 && total > int'(cutoff_q) * win) begin
        res.detected = 1'b1;
        restart_detector();
      end
    end
    res.window_total = total[TOTAL_W-1:0];
    res.cooling = (cool_count < 0);
    return res;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_CUTOFF:  cutoff_q = data;
      REG_WINDOW:  wsize_q = data[WSIZE_W-1:0];
      REG_COOLOFF: cooloff_q = data;
      default: ;
    endcase
  endfunction

  // Leaves cfg_valid high; the caller lowers it after its last write.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] cut, input logic [7:0] wdata,
                           input logic [7:0] cool);
    drain_results();
    write_register(REG_CUTOFF, cut);
    write_register(REG_WINDOW, wdata);
    write_register(REG_COOLOFF, cool);
    cfg_valid <= 1'b0;
  endtask

  // Leaves in_valid high so back-to-back items stream without a gap.
  task automatic send_item(input logic [SCORE_W-1:0] score, input logic clr);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_score         <= score;
    in_clear_request <= clr;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(score_step(score, clr));
    accepted_items++;
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_detected, out_window_total, out_cooling};
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOWN_MISMATCHES)
          $display("unexpected result: det=%0d total=%0d cool=%0d",
                   got.detected, got.window_total, got.cooling);
      end else begin
        want = expected_results.pop_front();
        if (got.detected !== want.detected || got.window_total !== want.window_total ||
            got.cooling !== want.cooling) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_MISMATCHES)
            $display({"mismatch: expected det=%0d total=%0d cool=%0d,",
                      " got det=%0d total=%0d cool=%0d"},
                     want.detected, want.window_total, want.cooling,
                     got.detected, got.window_total, got.cooling);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("windowed_score_detector verification failed");
      $finish;
    end
  end

  task automatic test_defaults();
    send_item(8'd0, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd255, 1'b1);
    send_item(8'd128, 1'b0);
    send_item(8'd246, 1'b0);
    send_item(8'd247, 1'b0);
  endtask

  task automatic test_arm_and_fire();
    configure(8'd10, 8'd3, 8'd2);
    send_item(8'd0, 1'b0);
    send_item(8'd5, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd9, 1'b0);
    send_item(8'd0, 1'b1);
    send_item(8'd255, 1'b0);
  endtask

  task automatic test_window_extremes();
    // zero window acts as one; zero cutoff fires on any nonzero score
    configure(8'd0, 8'd0, 8'd0);
    send_item(8'd0, 1'b0);
    send_item(8'd1, 1'b0);
    send_item(8'd0, 1'b0);
    // oversize window clamps to the maximum
    configure(8'd255, 8'hFF, 8'd0);
    repeat (3) send_item(8'd255, 1'b0);
    configure(8'd128, 8'hF0, 8'd255);
    send_item(8'd200, 1'b0);
    send_item(8'd200, 1'b0);
    drain_results();
    write_register(REG_SPARE, 8'hA5);
    write_register(REG_WINDOW, 8'd2);
    cfg_valid <= 1'b0;
    send_item(8'd200, 1'b0);
    configure(8'd255, 8'd1, 8'd0);
    send_item(8'd255, 1'b0);
  endtask

  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    configure(8'd100, 8'd4, 8'd2);
    // hold the output long enough to back up the input
    hold_cycles = 80;
    repeat (24) send_item(8'($urandom_range(255)), 1'b0);
    drain_results();
    stall_pct = 36;
    repeat (12) send_item(8'($urandom_range(255)), $urandom_range(9) == 0);
    drain_results();
    repeat (12) send_item(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic test_random_traffic(input int idle, input int stall, input int count);
    int         stop_at;
    int         round_end;
    int         kind;
    int         run_len;
    logic [7:0] cut;
    logic [4:0] wsz;
    logic [2:0] pad;
    logic [7:0] cool;
    idle_pct  = idle;
    stall_pct = stall;
    stop_at = accepted_items + count;
    while (accepted_items < stop_at) begin
      cut  = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 8'd255 : 8'd0)
                                      : 8'($urandom_range(254, 1));
      wsz  = ($urandom_range(5) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16, 1));
      pad  = 3'($urandom_range(7));
      cool = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(8));
      configure(cut, {pad, wsz}, cool);
      round_end = accepted_items + 24 + $urandom_range(12);
      while (accepted_items < round_end) begin
        kind = $urandom_range(99);
        if (kind < 45) begin
          // below-cutoff run to arm the detector
          run_len = cooloff_q + $urandom_range(3);
          repeat (run_len)
            send_item((cutoff_q == 0) ? 8'd0 : 8'($urandom_range(cutoff_q - 1)), 1'b0);
        end else if (kind < 80) begin
          // above-cutoff run long enough to fill the window
          run_len = active_window() + $urandom_range(2);
          repeat (run_len)
            send_item((cutoff_q == 255) ? 8'd255 : 8'($urandom_range(255, cutoff_q + 1)),
                      1'b0);
        end else if (kind < 92) begin
          repeat ($urandom_range(4, 1))
            send_item(8'($urandom_range(255)), $urandom_range(19) == 0);
        end else begin
          send_item(8'($urandom_range(255)), 1'b1);
        end
      end
    end
  endtask

  initial begin
    cutoff_q  = CUTOFF_RST;
    wsize_q   = WINDOW_RST;
    cooloff_q = COOLOFF_RST;
    restart_detector();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_defaults();
    test_arm_and_fire();
    test_window_extremes();
    test_backpressure();
    test_random_traffic(0, 0, 100);
    test_random_traffic(59, 0, 100);
    test_random_traffic(0, 59, 100);
    test_random_traffic(36, 36, 100);
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("windowed_score_detector verification clean");
    else
      $display("windowed_score_detector verification failed");
    $finish;
  end

endmodule
